/* rtl/core/bsi_pkg.sv */
// bsi_pkg: shared types and constants for the battery soc interpolator
// no dependencies; used by the interfaces and every rtl/core module

package bsi_pkg;

    localparam int VOLT_W     = 16;
    localparam int PCT_W      = 7;
    localparam int POINT_W    = 23;
    localparam int SOC_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;
    localparam int COUNT_W    = 3;
    localparam int MUL_W      = 17;
    localparam int PROD_W     = 34;
    localparam int SUB_W      = 32;
    localparam int ACC_W      = 25;
    localparam int LIM_W      = 31;
    localparam int DIV_STEPS  = 15;
    localparam int CNT_W      = 4;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN      = 3'd7;

    // reset values of the config registers
    localparam logic [COUNT_W-1:0] POINT_COUNT_RST = 3'd2;
    localparam logic [POINT_W-1:0] POINT0_RST      = 23'd11800;
    localparam logic [POINT_W-1:0] POINT1_RST      = 23'd6566300;
    localparam logic [VOLT_W-1:0]  MARGIN_RST      = 16'd400;

    localparam logic [PCT_W-1:0]  PCT_EMPTY     = 7'd0;
    localparam logic [PCT_W-1:0]  PCT_FULL      = 7'd100;
    localparam logic [SOC_W-1:0]  SOC_MAX_Q8    = 15'd25856;
    localparam logic [SOC_W-1:0]  SOC_FULL_Q8   = 15'd25600;
    localparam logic [MUL_W-1:0]  SOC_LIMIT_MUL = 17'd25857;

    typedef enum logic [1:0] {
        ST_BELOW    = 2'd0,
        ST_INTERP   = 2'd1,
        ST_FULL     = 2'd2,
        ST_CHARGING = 2'd3
    } soc_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL_BASE,
        S_MUL_SLOPE,
        S_MUL_LIMIT,
        S_CHECK,
        S_DIV,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [MUL_W-1:0] mul_a;
        logic [MUL_W-1:0] mul_b;
        logic [SUB_W-1:0] sub_a;
        logic [SUB_W-1:0] sub_b;
    } alu_req_t;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic [SUB_W-1:0]  diff;
        logic              ge;
    } alu_rsp_t;

endpackage

/* rtl/core/bsi_if.sv */
// bsi_if: valid/ready channel interfaces for voltage samples and soc results
// depends on bsi_pkg

interface bsi_in_if;
    import bsi_pkg::*;

    logic              valid;
    logic              ready;
    logic [VOLT_W-1:0] voltage_mv;

    modport source (output valid, output voltage_mv, input ready);
    modport sink (input valid, input voltage_mv, output ready);
endinterface

interface bsi_out_if;
    import bsi_pkg::*;

    logic             valid;
    logic             ready;
    logic [SOC_W-1:0] soc_q8;
    logic [1:0]       soc_status;

    modport source (output valid, output soc_q8, output soc_status, input ready);
    modport sink (input valid, input soc_q8, input soc_status, output ready);
endinterface

/* rtl/core/bsi_cfg.sv */
// bsi_cfg: configuration register file (point count, breakpoints, margin)
// depends on bsi_pkg

module bsi_cfg #(
    parameter int MAX_POINTS = 6
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           cfg_we,
    input  logic [bsi_pkg::CFG_IDX_W-1:0]                  cfg_index,
    input  logic [bsi_pkg::CFG_DATA_W-1:0]                 cfg_data,
    output logic [bsi_pkg::COUNT_W-1:0]                    point_count,
    output logic [bsi_pkg::VOLT_W-1:0]                     margin_mv,
    output logic [MAX_POINTS-1:0][bsi_pkg::POINT_W-1:0]    points
);
    import bsi_pkg::*;

    logic [COUNT_W-1:0]                  count_reg;
    logic [VOLT_W-1:0]                   margin_reg;
    logic [MAX_POINTS-1:0][POINT_W-1:0]  points_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= POINT_COUNT_RST;
            margin_reg <= MARGIN_RST;
            for (int k = 0; k < MAX_POINTS; k++)
            begin
                if (k == 0)
                    points_reg[k] <= POINT0_RST;
                else if (k == 1)
                    points_reg[k] <= POINT1_RST;
                else
                    points_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_POINT_COUNT)
                count_reg <= cfg_data[COUNT_W-1:0];
            if (cfg_index == REG_MARGIN)
                margin_reg <= cfg_data[VOLT_W-1:0];
            for (int k = 0; k < MAX_POINTS; k++)
            begin
                if (cfg_index == CFG_IDX_W'(int'(REG_POINT_0) + k))
                    points_reg[k] <= cfg_data[POINT_W-1:0];
            end
        end
    end

    assign point_count = count_reg;
    assign margin_mv   = margin_reg;
    assign points      = points_reg;

endmodule

/* rtl/core/bsi_alu.sv */
// bsi_alu: shared arithmetic unit, one signed multiplier and one subtract/compare
// depends on bsi_pkg

module bsi_alu (
    input  bsi_pkg::alu_req_t req,
    output bsi_pkg::alu_rsp_t rsp
);
    import bsi_pkg::*;

    logic [SUB_W:0] diff_wide;

    assign rsp.prod  = PROD_W'($signed(req.mul_a) * $signed(req.mul_b));
    assign diff_wide = {1'b0, req.sub_a} - {1'b0, req.sub_b};
    assign rsp.diff  = diff_wide[SUB_W-1:0];
    assign rsp.ge    = ~diff_wide[SUB_W];

endmodule

/* rtl/core/bsi_ctrl.sv */
// bsi_ctrl: sequencer that scans breakpoints, forms the interpolation and divides
// depends on bsi_pkg and bsi_if; drives the shared bsi_alu unit through its request and response ports

module bsi_ctrl #(
    parameter int MAX_POINTS = 6
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    bsi_in_if.sink                                       sample,
    bsi_out_if.source                                    soc,
    input  logic [bsi_pkg::COUNT_W-1:0]                  point_count,
    input  logic [bsi_pkg::VOLT_W-1:0]                   margin_mv,
    input  logic [MAX_POINTS-1:0][bsi_pkg::POINT_W-1:0]  points,
    output bsi_pkg::alu_req_t                            alu_req,
    input  bsi_pkg::alu_rsp_t                            alu_rsp
);
    import bsi_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam logic [COUNT_W-1:0] MaxPts = COUNT_W'(MAX_POINTS);

    state_t                   state_reg, state_next;
    logic [VOLT_W-1:0]        v_reg, v_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [PCT_W-1:0]         sp_reg, sp_next;
    logic [VOLT_W-1:0]        sv_reg, sv_next;
    logic [PCT_W-1:0]         ep_reg, ep_next;
    logic [VOLT_W-1:0]        ev_reg, ev_next;
    logic signed [ACC_W-1:0]  t_reg, t_next;
    logic [LIM_W-1:0]         lim_reg, lim_next;
    logic [SUB_W-1:0]         rem_reg, rem_next;
    logic [SUB_W-1:0]         dsh_reg, dsh_next;
    logic [SOC_W-1:0]         q_reg, q_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [SOC_W-1:0]         res_q8_reg, res_q8_next;
    soc_status_t              res_st_reg, res_st_next;
    logic                     out_valid_reg, out_valid_next;
    logic [SOC_W-1:0]         out_q8_reg, out_q8_next;
    soc_status_t              out_st_reg, out_st_next;

    // scan decisions for the breakpoint at idx_reg
    logic [POINT_W-1:0]  pt;
    logic [PCT_W-1:0]    pt_pct;
    logic [VOLT_W-1:0]   pt_mv;
    logic [COUNT_W-1:0]  n_last;
    logic                hit_below;
    logic                hit_full;
    logic                hit_stop;
    logic                at_last;
    logic                charging;
    logic [SOC_W-1:0]    pct_q8;
    logic [VOLT_W-1:0]   den;
    logic [VOLT_W-1:0]   dv;
    logic [PCT_W:0]      dp;
    logic                t_nonpos;
    logic [SUB_W-1:0]    num;
    logic                div_last;
    logic                out_free;

    assign pt        = points[idx_reg];
    assign pt_pct    = pt[POINT_W-1:VOLT_W];
    assign pt_mv     = pt[VOLT_W-1:0];
    assign hit_below = (pt_pct == PCT_EMPTY) && (v_reg < pt_mv);
    assign hit_full  = (pt_pct == PCT_FULL) && (v_reg >= pt_mv);
    assign hit_stop  = (pt_mv > v_reg);
    assign charging  = {1'b0, v_reg} >= ({1'b0, pt_mv} + {1'b0, margin_mv});
    assign pct_q8    = {pt_pct, 8'd0};
    assign at_last   = (COUNT_W'(idx_reg) == n_last);

    always_comb
    begin
        if (point_count < 3'd2)
            n_last = 3'd1;
        else if (point_count > MaxPts)
            n_last = MaxPts - 3'd1;
        else
            n_last = point_count - 3'd1;
    end

    assign den      = ev_reg - sv_reg;
    assign dv       = v_reg - sv_reg;
    assign dp       = {1'b0, ep_reg} - {1'b0, sp_reg};
    assign t_nonpos = t_reg[ACC_W-1] || (t_reg == '0);
    assign num      = {t_reg[ACC_W-2:0], 8'd0};
    assign div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign out_free = !out_valid_reg || soc.ready;

    assign sample.ready   = (state_reg == S_IDLE);
    assign soc.valid      = out_valid_reg;
    assign soc.soc_q8     = out_q8_reg;
    assign soc.soc_status = out_st_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (hit_below || hit_full)
                    state_next = S_FIN;
                else if (hit_stop)
                    state_next = S_MUL_BASE;
                else if (at_last)
                    state_next = S_FIN;
            end
            S_MUL_BASE:  state_next = S_MUL_SLOPE;
            S_MUL_SLOPE: state_next = S_MUL_LIMIT;
            S_MUL_LIMIT: state_next = S_CHECK;
            S_CHECK:
            begin
                if (t_nonpos || alu_rsp.ge)
                    state_next = S_FIN;
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        v_next         = v_reg;
        idx_next       = idx_reg;
        sp_next        = sp_reg;
        sv_next        = sv_reg;
        ep_next        = ep_reg;
        ev_next        = ev_reg;
        t_next         = t_reg;
        lim_next       = lim_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        res_q8_next    = res_q8_reg;
        res_st_next    = res_st_reg;
        out_q8_next    = out_q8_reg;
        out_st_next    = out_st_reg;
        out_valid_next = out_valid_reg;
        alu_req        = '0;

        if (out_valid_reg && soc.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    v_next   = sample.voltage_mv;
                    idx_next = '0;
                    sp_next  = '0;
                    sv_next  = '0;
                end
            end
            S_SCAN:
            begin
                ep_next = pt_pct;
                ev_next = pt_mv;
                if (hit_below)
                begin
                    res_q8_next = '0;
                    res_st_next = ST_BELOW;
                end
                else if (hit_full)
                begin
                    res_q8_next = charging ? SOC_MAX_Q8 : SOC_FULL_Q8;
                    res_st_next = charging ? ST_CHARGING : ST_FULL;
                end
                else if (!hit_stop)
                begin
                    sp_next  = pt_pct;
                    sv_next  = pt_mv;
                    idx_next = idx_reg + 1'b1;
                    // ran off the end of the table: hold at the last percent
                    res_q8_next = (pct_q8 > SOC_MAX_Q8) ? SOC_MAX_Q8 : pct_q8;
                    res_st_next = ST_INTERP;
                end
            end
            S_MUL_BASE:
            begin
                alu_req.mul_a = MUL_W'(sp_reg);
                alu_req.mul_b = {1'b0, den};
                t_next        = alu_rsp.prod[ACC_W-1:0];
            end
            S_MUL_SLOPE:
            begin
                alu_req.mul_a = {{(MUL_W-PCT_W-1){dp[PCT_W]}}, dp};
                alu_req.mul_b = {1'b0, dv};
                t_next        = t_reg + $signed(alu_rsp.prod[ACC_W-1:0]);
            end
            S_MUL_LIMIT:
            begin
                alu_req.mul_a = {1'b0, den};
                alu_req.mul_b = SOC_LIMIT_MUL;
                lim_next      = alu_rsp.prod[LIM_W-1:0];
            end
            S_CHECK:
            begin
                alu_req.sub_a = num;
                alu_req.sub_b = {1'b0, lim_reg};
                res_st_next   = ST_INTERP;
                if (t_nonpos)
                    res_q8_next = '0;
                else if (alu_rsp.ge)
                    res_q8_next = SOC_MAX_Q8;
                else
                begin
                    rem_next = num;
                    dsh_next = {2'b00, den, 14'd0};
                    q_next   = '0;
                    cnt_next = '0;
                end
            end
            S_DIV:
            begin
                alu_req.sub_a = rem_reg;
                alu_req.sub_b = dsh_reg;
                if (alu_rsp.ge)
                    rem_next = alu_rsp.diff;
                q_next   = {q_reg[SOC_W-2:0], alu_rsp.ge};
                dsh_next = {1'b0, dsh_reg[SUB_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (div_last)
                    res_q8_next = {q_reg[SOC_W-2:0], alu_rsp.ge};
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_q8_next    = res_q8_reg;
                    out_st_next    = res_st_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        idx_reg    <= idx_next;
        sp_reg     <= sp_next;
        sv_reg     <= sv_next;
        ep_reg     <= ep_next;
        ev_reg     <= ev_next;
        t_reg      <= t_next;
        lim_reg    <= lim_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        q_reg      <= q_next;
        cnt_reg    <= cnt_next;
        res_q8_reg <= res_q8_next;
        res_st_reg <= res_st_next;
        out_q8_reg <= out_q8_next;
        out_st_reg <= out_st_next;
    end

`ifndef SYNTHESIS
    a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result word appeared without passing the finish state");

    a_soc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_q8_reg <= SOC_MAX_Q8))
        else $error("soc result above 101 percent");

    a_charging_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_st_reg == ST_CHARGING)) |-> (out_q8_reg == SOC_MAX_Q8))
        else $error("charging status with a value other than 101 percent");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg < CNT_W'(DIV_STEPS)))
        else $error("divider ran past its last step");

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_valid_reg && !soc.ready) |=> (state_reg == S_FIN))
        else $error("finished result dropped while output was stalled");
`endif

endmodule

/* rtl/core/battery_soc_interpolator.sv */
// battery_soc_interpolator: top level of the battery state of charge interpolator
// depends on bsi_pkg, bsi_if, bsi_cfg, bsi_alu and bsi_ctrl
//
// channel   dir   handshake          payload
// sample    in    valid / ready      voltage_mv [15:0]
// soc       out   valid / ready      soc_q8 [14:0], soc_status [1:0]
// cfg       in    cfg_we (no ready)  cfg_index [2:0], cfg_data [22:0]
//
// one sample at a time: accept, then scan the breakpoints in order (up to MAX_POINTS);
// interpolated samples add the base, slope and limit products on the shared multiplier,
// one range check and 15 restore-divide steps on the shared subtractor; below, full
// and charging exits go straight from the scan to the finish state
// sample.ready is high only while the sequencer is idle; a result waits in the output
// register while the next sample is taken, and the sequencer holds if it is still full
// rst_n is asynchronous, active low; it restores the default two-point table

module battery_soc_interpolator #(
    parameter int MAX_POINTS = 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    bsi_in_if.sink                             sample,
    bsi_out_if.source                          soc,
    input  logic                               cfg_we,
    input  logic [bsi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bsi_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bsi_pkg::*;

    // config register outputs
    logic [COUNT_W-1:0]                  point_count;
    logic [VOLT_W-1:0]                   margin_mv;
    logic [MAX_POINTS-1:0][POINT_W-1:0]  points;

    // shared arithmetic unit traffic
    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    bsi_cfg #(
        .MAX_POINTS (MAX_POINTS)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .point_count (point_count),
        .margin_mv   (margin_mv),
        .points      (points)
    );

    // one multiplier and one subtract/compare shared by the multiply, check and divide steps
    bsi_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // sequencer: breakpoint scan, interpolation products, divide, output register
    bsi_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .soc         (soc),
        .point_count (point_count),
        .margin_mv   (margin_mv),
        .points      (points),
        .alu_req     (alu_req),
        .alu_rsp     (alu_rsp)
    );

endmodule
